[rtl/stq_pkg.sv]
// Package for the sorted timer queue: field widths, command and status codes,
// and the beat payload types. No dependencies.
package stq_pkg;

   // Fixed field widths of the request and response beats
   localparam int unsigned DUE_TIME_W   = 32;
   localparam int unsigned ENTRY_ID_W   = 8;
   localparam int unsigned FILL_COUNT_W = 5;
   localparam int unsigned STATUS_W     = 2;

   // Command codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY  = 2'd2;

   typedef struct packed {
      logic                  command;
      logic [DUE_TIME_W-1:0] due_time;
      logic [ENTRY_ID_W-1:0] entry_id;
   } req_type;

   typedef struct packed {
      logic                    head_valid;
      logic [DUE_TIME_W-1:0]   head_time;
      logic [ENTRY_ID_W-1:0]   head_id;
      logic [FILL_COUNT_W-1:0] fill_count;
      logic [STATUS_W-1:0]     status;
   } rsp_type;

endpackage

[rtl/stq_req_if.sv]
// Request channel of the sorted timer queue: valid/ready plus a command beat.
// Depends on stq_pkg.
interface stq_req_if;
   logic             valid;
   logic             ready;
   stq_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/stq_rsp_if.sv]
// Response channel of the sorted timer queue: valid/ready plus a head/status beat.
// Depends on stq_pkg.
interface stq_rsp_if;
   logic             valid;
   logic             ready;
   stq_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/sorted_timer_queue_unit.sv]
// Sorted timer queue: slot memory, insertion/removal sequencer, response register.
// Depends on stq_pkg, stq_req_if and stq_rsp_if.
//
//  channel   | dir | beat contents
//  ----------+-----+-------------------------------------------------
//  req_chan  | in  | command, due_time, entry_id
//  rsp_chan  | out | head_valid, head_time, head_id, fill_count, status
//
// A push walks down from the tail, moving one later entry up per cycle through
// the single slot memory port pair; a pop moves one entry down per cycle.
// A push into a non-full queue compares and moves entries, then writes the new entry;
// a pop moves any later entries down; a dropped beat (push when full, pop when empty)
// skips both. Each then reads the head slot and responds. Reset empties the queue at once; slot contents
// stay undefined until written.
// A finished response waits in its output register while the next beat is taken;
// the sequencer stalls only if a second response is ready before the first leaves.
module sorted_timer_queue_unit #(
   parameter int unsigned QUEUE_DEPTH = 16,
   parameter int unsigned TIME_BITS   = 32,
   parameter int unsigned ID_BITS     = 8
) (
   input  logic       clock,
   input  logic       reset,
   stq_req_if.sink    req_chan,
   stq_rsp_if.source  rsp_chan
);

   localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Sequencer state codes
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_PUSH_CMP  = 3'd1;
   localparam logic [2:0] ST_PUSH_WR   = 3'd2;
   localparam logic [2:0] ST_POP_SHIFT = 3'd3;
   localparam logic [2:0] ST_HEAD_RD   = 3'd4;
   localparam logic [2:0] ST_RESP      = 3'd5;

   // Slot memory
   logic [TIME_BITS-1:0] slot_time_mem [QUEUE_DEPTH];
   logic [ID_BITS-1:0]   slot_id_mem   [QUEUE_DEPTH];
   logic [TIME_BITS-1:0] rd_time_ff;
   logic [ID_BITS-1:0]   rd_id_ff;

   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [TIME_BITS-1:0] wr_time;
   logic [ID_BITS-1:0]   wr_id;

   // Control and beat registers
   logic [2:0]                   state_ff, state_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [TIME_BITS-1:0]         key_time_ff, key_time_in;
   logic [ID_BITS-1:0]           key_id_ff, key_id_in;
   logic [stq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   stq_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   // Width fitting between fixed port fields and parameterized storage
   logic [TIME_BITS+stq_pkg::DUE_TIME_W-1:0]   req_time_ext;
   logic [ID_BITS+stq_pkg::ENTRY_ID_W-1:0]     req_id_ext;
   logic [TIME_BITS+stq_pkg::DUE_TIME_W-1:0]   head_time_ext;
   logic [ID_BITS+stq_pkg::ENTRY_ID_W-1:0]     head_id_ext;
   logic [CNT_W+stq_pkg::FILL_COUNT_W-1:0]     fill_ext;

   logic             req_fire;
   logic             rsp_free;
   logic [IDX_W-1:0] idx_dec;
   logic [IDX_W-1:0] idx_inc;
   logic [CNT_W:0]   idx_plus2;

   assign req_time_ext  = {{TIME_BITS{1'b0}}, req_chan.payload.due_time};
   assign req_id_ext    = {{ID_BITS{1'b0}}, req_chan.payload.entry_id};
   assign head_time_ext = {{stq_pkg::DUE_TIME_W{1'b0}}, rd_time_ff};
   assign head_id_ext   = {{stq_pkg::ENTRY_ID_W{1'b0}}, rd_id_ff};
   assign fill_ext      = {{stq_pkg::FILL_COUNT_W{1'b0}}, count_ff};

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign req_fire         = req_chan.valid && req_chan.ready;
   assign rsp_free         = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   assign idx_dec   = idx_ff - IDX_W'(1);
   assign idx_inc   = idx_ff + IDX_W'(1);
   assign idx_plus2 = (CNT_W + 1)'(idx_ff) + (CNT_W + 1)'(2);

   // Sequencer: at most one memory read and one write per cycle
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      key_time_in  = key_time_ff;
      key_id_in    = key_id_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_time      = rd_time_ff;
      wr_id        = rd_id_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               key_time_in = req_time_ext[TIME_BITS-1:0];
               key_id_in   = req_id_ext[ID_BITS-1:0];
               status_in   = stq_pkg::STATUS_OK;
               if (req_chan.payload.command == stq_pkg::CMD_PUSH) begin
                  if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     status_in = stq_pkg::STATUS_PUSH_FULL;
                     state_in  = ST_HEAD_RD;
                  end else if (count_ff == '0) begin
                     idx_in   = '0;
                     state_in = ST_PUSH_WR;
                  end else begin
                     // Start at the tail: look at the last held entry
                     idx_in   = count_ff[IDX_W-1:0];
                     rd_en    = 1'b1;
                     rd_addr  = count_ff[IDX_W-1:0] - IDX_W'(1);
                     state_in = ST_PUSH_CMP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = stq_pkg::STATUS_POP_EMPTY;
                     state_in  = ST_HEAD_RD;
                  end else if (count_ff == CNT_W'(1)) begin
                     count_in = count_ff - CNT_W'(1);
                     state_in = ST_HEAD_RD;
                  end else begin
                     idx_in   = '0;
                     rd_en    = 1'b1;
                     rd_addr  = IDX_W'(1);
                     state_in = ST_POP_SHIFT;
                  end
               end
            end
         end

         ST_PUSH_CMP: begin
            // Move a strictly later entry up one slot, else stop here
            if (key_time_ff < rd_time_ff) begin
               wr_en  = 1'b1;
               idx_in = idx_dec;
               if (idx_dec != '0) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_dec - IDX_W'(1);
               end else begin
                  state_in = ST_PUSH_WR;
               end
            end else begin
               state_in = ST_PUSH_WR;
            end
         end

         ST_PUSH_WR: begin
            wr_en    = 1'b1;
            wr_time  = key_time_ff;
            wr_id    = key_id_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = ST_HEAD_RD;
         end

         ST_POP_SHIFT: begin
            // Move the next entry down one slot
            wr_en = 1'b1;
            if (idx_plus2 < (CNT_W + 1)'(count_ff)) begin
               rd_en   = 1'b1;
               rd_addr = idx_inc + IDX_W'(1);
               idx_in  = idx_inc;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_HEAD_RD;
            end
         end

         ST_HEAD_RD: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = ST_RESP;
         end

         ST_RESP: begin
            // Load the response beat once the output register is free
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.head_valid = (count_ff != '0);
               rsp_data_in.head_time  = (count_ff != '0) ?
                                        head_time_ext[stq_pkg::DUE_TIME_W-1:0] : '0;
               rsp_data_in.head_id    = (count_ff != '0) ?
                                        head_id_ext[stq_pkg::ENTRY_ID_W-1:0] : '0;
               rsp_data_in.fill_count = fill_ext[stq_pkg::FILL_COUNT_W-1:0];
               rsp_data_in.status     = status_ff;
               state_in               = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_time_mem[wr_addr] <= wr_time;
         slot_id_mem[wr_addr]   <= wr_id;
      end
      if (rd_en) begin
         rd_time_ff <= slot_time_mem[rd_addr];
         rd_id_ff   <= slot_id_mem[rd_addr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Beat and walk registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      key_time_ff <= key_time_in;
      key_id_ff   <= key_id_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
